// ----- rtl/rle_sprite_scaled_blit_macros.svh -----
// Assertion helpers used by the RTL decode stage. Each use expects clk and rst_n in scope.
`ifndef RLE_SPRITE_SCALED_BLIT_MACROS_SVH
`define RLE_SPRITE_SCALED_BLIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RSB_ASSERT_NOW(LBL, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Next-cycle implication, checked out of reset.
`define RSB_ASSERT_NEXT(LBL, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

// ----- rtl/rsb_pkg.sv -----
`default_nettype none

package rsb_pkg;

  localparam int ADDRESS_WIDTH_DEF = 24;
  localparam int MAX_SCALE_DEF     = 8;

  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int PIXEL_ADDR_W = 24;
  localparam int STRIDE_W     = 13;
  localparam int SKIP_BIT     = 7;   // 0x80 marks a skip control byte

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_LINE_STRIDE = 3'd2,
    REG_ROW_COUNT   = 3'd3,
    REG_SCALE       = 3'd4,
    REG_FILL_COLOUR = 3'd5,
    REG_COLOURIZE   = 3'd6
  } cfg_reg_t;

  // Settings read directly by the decode stage.
  typedef struct packed {
    logic [7:0] row_count;
    logic [3:0] scale;        // already clamped to 1..MAX_SCALE
    logic [7:0] fill_colour;
    logic       colourize;
  } rsb_live_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/rsb_cfg.sv -----
`default_nettype none

module rsb_cfg import rsb_pkg::*; #(
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF,
  parameter int MAX_SCALE     = MAX_SCALE_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_write_enable,
  input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  output rsb_live_cfg_t                 live_cfg,
  output logic      [ADDRESS_WIDTH-1:0] origin_addr,
  output logic      [ADDRESS_WIDTH-1:0] row_step
);

  logic [15:0]          origin_x_r;
  logic [15:0]          origin_y_r;
  logic [STRIDE_W-1:0]  stride_r;
  logic [7:0]           row_count_r;
  logic [3:0]           scale_r;
  logic [7:0]           fill_r;
  logic                 colourize_r;
  logic [3:0]           scale_clamped;

  logic [ADDRESS_WIDTH-1:0] origin_addr_r;
  logic [ADDRESS_WIDTH-1:0] row_step_r;
  logic signed [29:0]       origin_prod;
  logic [31:0]              origin_sum;
  logic [16:0]              step_prod;

  // zero acts as 1, anything past MAX_SCALE saturates
  always_comb begin
    scale_clamped = cfg_data[3:0];
    if (cfg_data[3:0] == 4'd0) begin
      scale_clamped = 4'd1;
    end else if (32'(cfg_data[3:0]) > 32'(MAX_SCALE)) begin
      scale_clamped = 4'(MAX_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      stride_r    <= STRIDE_W'(640);
      row_count_r <= 8'd1;
      scale_r     <= 4'd1;
      fill_r      <= '0;
      colourize_r <= 1'b0;
    end else if (cfg_write_enable) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:    origin_x_r  <= cfg_data[15:0];
        REG_ORIGIN_Y:    origin_y_r  <= cfg_data[15:0];
        REG_LINE_STRIDE: stride_r    <= cfg_data[STRIDE_W-1:0];
        REG_ROW_COUNT:   row_count_r <= cfg_data[7:0];
        REG_SCALE:       scale_r     <= scale_clamped;
        REG_FILL_COLOUR: fill_r      <= cfg_data[7:0];
        REG_COLOURIZE:   colourize_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Derived addresses, refreshed every cycle; settings must only move while idle, not enforced here.
  assign origin_prod = $signed(origin_y_r) * $signed({1'b0, stride_r});
  assign origin_sum  = 32'(origin_prod) + 32'($signed(origin_x_r));
  assign step_prod   = stride_r * scale_r;

  always_ff @(posedge clk) begin
    origin_addr_r <= origin_sum[ADDRESS_WIDTH-1:0];
    row_step_r    <= ADDRESS_WIDTH'(step_prod);
  end

  assign origin_addr = origin_addr_r;
  assign row_step    = row_step_r;

  assign live_cfg.row_count   = row_count_r;
  assign live_cfg.scale       = scale_r;
  assign live_cfg.fill_colour = fill_r;
  assign live_cfg.colourize   = colourize_r;

endmodule

`default_nettype wire

// ----- rtl/rsb_decode.sv -----
`default_nettype none

module rsb_decode import rsb_pkg::*; #(
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF,
  parameter int MAX_SCALE     = MAX_SCALE_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,
  input  wire logic [7:0]               data_byte,
  input  wire logic                     sprite_start,
  input  wire rsb_live_cfg_t            live_cfg,
  input  wire logic [ADDRESS_WIDTH-1:0] origin_addr,
  input  wire logic [ADDRESS_WIDTH-1:0] row_step,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic                          out_write_enable,
  output logic [PIXEL_ADDR_W-1:0]       out_pixel_address,
  output logic [7:0]                    out_pixel_value,
  output logic [3:0]                    out_block_size,
  output logic                          out_sprite_done
);

  localparam int PAW = (ADDRESS_WIDTH > PIXEL_ADDR_W) ? ADDRESS_WIDTH : PIXEL_ADDR_W;

  logic [ADDRESS_WIDTH-1:0] base_r, base_nxt, base_cur;
  logic [ADDRESS_WIDTH-1:0] cursor_r, cursor_nxt, cursor_cur;
  logic [6:0]               run_r, run_nxt, run_cur;
  logic [7:0]               rows_r, rows_nxt, rows_cur;
  logic                     active_r, active_nxt, active_cur;

  logic                     valid_r, valid_nxt;
  logic                     we_r, we_nxt;
  logic [PIXEL_ADDR_W-1:0]  addr_r, addr_nxt;
  logic [7:0]               value_r, value_nxt;
  logic [3:0]               size_r, size_nxt;
  logic                     done_r, done_nxt;

  logic [7:0]               skip_len;
  logic [11:0]              skip_off;
  logic [ADDRESS_WIDTH-1:0] new_base;
  logic [PAW-1:0]           cursor_ext;
  logic                     produce;

  // sprite start rearms before the byte is decoded
  assign base_cur   = sprite_start ? origin_addr : base_r;
  assign cursor_cur = sprite_start ? origin_addr : cursor_r;
  assign rows_cur   = sprite_start ? live_cfg.row_count : rows_r;
  assign run_cur    = sprite_start ? 7'd0 : run_r;
  assign active_cur = sprite_start | active_r;

  assign skip_len   = 8'd0 - data_byte;
  assign skip_off   = skip_len * live_cfg.scale;
  assign new_base   = base_cur + row_step;
  assign cursor_ext = PAW'(cursor_cur);

  always_comb begin
    base_nxt   = base_r;
    cursor_nxt = cursor_r;
    run_nxt    = run_r;
    rows_nxt   = rows_r;
    active_nxt = active_r;
    produce    = 1'b0;
    we_nxt     = we_r;
    addr_nxt   = addr_r;
    value_nxt  = value_r;
    size_nxt   = size_r;
    done_nxt   = done_r;

    if (step && active_cur) begin
      base_nxt   = base_cur;
      cursor_nxt = cursor_cur;
      run_nxt    = run_cur;
      rows_nxt   = rows_cur;
      active_nxt = 1'b1;
      size_nxt   = live_cfg.scale;

      if (run_cur != 7'd0) begin
        // literal pixel: one square block at the cursor
        produce    = 1'b1;
        we_nxt     = 1'b1;
        done_nxt   = 1'b0;
        addr_nxt   = cursor_ext[PIXEL_ADDR_W-1:0];
        value_nxt  = live_cfg.colourize ? live_cfg.fill_colour : data_byte;
        cursor_nxt = cursor_cur + ADDRESS_WIDTH'(live_cfg.scale);
        run_nxt    = run_cur - 7'd1;
      end else if (data_byte == 8'd0) begin
        // row end
        base_nxt   = new_base;
        cursor_nxt = new_base;
        rows_nxt   = rows_cur - 8'd1;
        if (rows_cur == 8'd1) begin
          active_nxt = 1'b0;
          produce    = 1'b1;
          we_nxt     = 1'b0;
          done_nxt   = 1'b1;
          addr_nxt   = '0;
          value_nxt  = '0;
        end
      end else if (data_byte[SKIP_BIT]) begin
        cursor_nxt = cursor_cur + ADDRESS_WIDTH'(skip_off);
      end else begin
        run_nxt = data_byte[6:0];
      end
    end

    if (step) begin
      valid_nxt = produce;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      cursor_r <= '0;
      run_r    <= '0;
      rows_r   <= '0;
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      base_r   <= base_nxt;
      cursor_r <= cursor_nxt;
      run_r    <= run_nxt;
      rows_r   <= rows_nxt;
      active_r <= active_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    we_r    <= we_nxt;
    addr_r  <= addr_nxt;
    value_r <= value_nxt;
    size_r  <= size_nxt;
    done_r  <= done_nxt;
  end

  assign out_valid         = valid_r;
  assign out_write_enable  = we_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_value   = value_r;
  assign out_block_size    = size_r;
  assign out_sprite_done   = done_r;

`include "rle_sprite_scaled_blit_macros.svh"

  `RSB_ASSERT_NOW(a_idle_no_run, !active_r, run_r == 7'd0, "open run while decoder idle")
  `RSB_ASSERT_NOW(a_kind_exclusive, valid_r, we_r ^ done_r, "result is neither write nor done")
  `RSB_ASSERT_NOW(a_block_size, valid_r,
                  (size_r != 4'd0) && (32'(size_r) <= 32'(MAX_SCALE)), "block size out of range")
  `RSB_ASSERT_NEXT(a_done_idles, step && produce && done_nxt, !active_r,
                   "decoder still active after sprite end")

endmodule

`default_nettype wire

// ----- rtl/rle_sprite_scaled_blit.sv -----
// Channel   | Handshake                        | Payload
// ----------+----------------------------------+-------------------------------------------
// input     | in_valid / in_ready              | in_data_byte, in_sprite_start
// result    | out_valid / out_ready            | out_write_enable, out_pixel_address,
//           |                                  | out_pixel_value, out_block_size, out_sprite_done
// config    | cfg_write_enable (no wait)       | cfg_index, cfg_data
//
// One byte per clock sustained while out_ready holds; a byte is captured in the input
// register, decoded from there, and its result (if any) is held in the out_ register.
// The input register and the result register bound the pipeline; between them sits the
// decode (address add plus a small 8x4 skip multiply).
// rst_n is synchronous, active low; decoder comes up idle until a sprite_start byte.
// An output stall holds the result register; one more byte waits in the input
// register, then in_ready drops.
`default_nettype none

module rle_sprite_scaled_blit import rsb_pkg::*; #(
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF,
  parameter int MAX_SCALE     = MAX_SCALE_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // encoded byte stream
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              in_data_byte,
  input  wire logic                    in_sprite_start,
  // block writes and sprite end marker
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_write_enable,
  output logic [PIXEL_ADDR_W-1:0]      out_pixel_address,
  output logic [7:0]                   out_pixel_value,
  output logic [3:0]                   out_block_size,
  output logic                         out_sprite_done,
  // register writes
  input  wire logic                    cfg_write_enable,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  rsb_live_cfg_t            live_cfg;
  logic [ADDRESS_WIDTH-1:0] origin_addr;
  logic [ADDRESS_WIDTH-1:0] row_step;

  // input register stage
  logic       s0_valid_r;
  logic [7:0] s0_data_r;
  logic       s0_start_r;
  logic       s0_go;

  // the held byte moves on whenever the result register is free or draining
  assign s0_go    = s0_valid_r && (!out_valid || out_ready);
  assign in_ready = !s0_valid_r || s0_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_data_r  <= in_data_byte;
      s0_start_r <= in_sprite_start;
    end
  end

  // settings plus precomputed origin address and row advance (stride * scale)
  rsb_cfg #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .MAX_SCALE     (MAX_SCALE)
  ) u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .live_cfg         (live_cfg),
    .origin_addr      (origin_addr),
    .row_step         (row_step)
  );

  // byte decode, cursor/row state and result register
  rsb_decode #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .MAX_SCALE     (MAX_SCALE)
  ) u_decode (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (s0_go),
    .data_byte         (s0_data_r),
    .sprite_start      (s0_start_r),
    .live_cfg          (live_cfg),
    .origin_addr       (origin_addr),
    .row_step          (row_step),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_write_enable  (out_write_enable),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_block_size    (out_block_size),
    .out_sprite_done   (out_sprite_done)
  );

endmodule

`default_nettype wire
